@@ rtl/core/sct_pkg.sv @@
// ============================================================================
// sct_pkg
// Shared types, constants and the sine table generator for the sine/cosine
// table with cubic interpolation.
// ============================================================================
package sct_pkg;

  // Phase: full turn is 2^24
  localparam int unsigned PHASE_WIDTH  = 24;
  localparam logic [PHASE_WIDTH-1:0] QUARTER_TURN = 24'h40_0000;

  // Defaults of the top-level parameters
  localparam int unsigned DEF_TABLE_SIZE    = 4096;
  localparam int unsigned DEF_FRACTION_BITS = 12;
  localparam int unsigned DEF_OUTPUT_BITS   = 16;

  // Datapath widths
  localparam int unsigned ROM_WIDTH   = 16;  // Q1.15 table entries
  localparam int unsigned COEF_WIDTH  = 20;  // doubled Catmull-Rom coefficients
  localparam int unsigned GUARD_BITS  = 16;
  localparam int unsigned T_WIDTH     = 37;  // Horner accumulator, |t| < 2^36
  localparam int unsigned T_LSB_BITS  = 32;  // accumulator LSB is 2^-32
  localparam int unsigned MUL_SPLIT   = 18;  // low slice of t per partial product

  // Table generator constants (Q30)
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam int unsigned     SERIES_TERMS = 9;
  localparam longint unsigned COS_DIV [SERIES_TERMS] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306};
  localparam longint unsigned SIN_DIV [SERIES_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342};

  // Stage enables of one Horner step
  typedef struct packed {
    logic mul;
    logic acc;
  } step_en_t;

  // Shift-subtract quotient, used only while building the table
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(2*pi*i/2^table_bits) in Q1.15, evaluated at elaboration
  function automatic logic [ROM_WIDTH-1:0] rom_entry(input int unsigned i,
                                                     input int unsigned table_bits);
    longint unsigned q;
    longint unsigned r;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned m;
    longint          sum;
    q    = (longint'(i) << 2) >> table_bits;
    r    = (longint'(i) << 2) - (q << table_bits);
    a    = (HALF_PI_Q30 * r + (64'd1 << (table_bits - 1))) >> table_bits;
    a2   = (a * a) >> 30;
    term = q[0] ? ONE_Q30 : a;
    sum  = longint'(term);
    for (int k = 0; k < SERIES_TERMS; k++) begin
      term = div_u64((term * a2) >> 30, q[0] ? COS_DIV[k] : SIN_DIV[k]);
      if (k[0] == 1'b0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    m = (longint'(sum) + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return q[1] ? ROM_WIDTH'(-m) : ROM_WIDTH'(m);
  endfunction

endpackage

@@ rtl/core/sine_cosine_table_cubic_interp.sv @@
// ============================================================================
// sine_cosine_table_cubic_interp
// Sine or cosine of a 24-bit binary angle from a banked sine table with
// Catmull-Rom cubic interpolation, rounded and saturated.
// ============================================================================
// Usage:
//   Input channel valid_i/stall_o carries kind_i (0 sine, 1 cosine) and
//   phase_i (2^24 is one full turn). A transfer happens on a rising edge with
//   valid_i high and stall_o low. Output channel valid_o/stall_i carries
//   value_o, signed Q1.(OUTPUT_BITS-1); one result per input, in order.
//   Throughput is one item per cycle while stall_i is low: address, table
//   read, coefficient, three Horner steps of two stages each (split
//   multiply, then add) and round/saturate are all registered stages.
//   The table is four banks of TABLE_SIZE/4 constant entries, so the four
//   neighbors of an index are read at once.
//   Reset clears all stage valid bits; the table is constant and needs no
//   fill. When stall_i holds a result, stages behind it keep advancing until
//   they run into it; stall_o rises only when every stage is full.
//   TABLE_SIZE must be a power of two.
// ============================================================================
module sine_cosine_table_cubic_interp import sct_pkg::*; #(
  parameter int unsigned TABLE_SIZE    = DEF_TABLE_SIZE,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int unsigned OUTPUT_BITS   = DEF_OUTPUT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic                          kind_i,
  input  logic [PHASE_WIDTH-1:0]        phase_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [OUTPUT_BITS-1:0] value_o
);

  localparam int unsigned TB = $clog2(TABLE_SIZE);

  localparam int unsigned ST_ADDR    = 0;
  localparam int unsigned ST_ROM     = 1;
  localparam int unsigned ST_COEF    = 2;
  localparam int unsigned ST_MUL1    = 3;
  localparam int unsigned ST_ACC1    = 4;
  localparam int unsigned ST_MUL2    = 5;
  localparam int unsigned ST_ACC2    = 6;
  localparam int unsigned ST_MUL3    = 7;
  localparam int unsigned ST_ACC3    = 8;
  localparam int unsigned ST_OUT     = 9;
  localparam int unsigned NUM_STAGES = 10;

  localparam int unsigned ROUND_SHIFT = T_LSB_BITS + 1 - OUTPUT_BITS;
  localparam logic signed [T_WIDTH:0] ROUND_HALF = (T_WIDTH + 1)'(1) <<< (ROUND_SHIFT - 1);
  localparam logic signed [T_WIDTH:0] SAT_HI =
    ((T_WIDTH + 1)'(1) <<< (OUTPUT_BITS - 1)) - (T_WIDTH + 1)'(1);
  localparam logic signed [T_WIDTH:0] SAT_LO = ~SAT_HI;

  // --------------------------------------------------------------------------
  // Stage control
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] valid_d, valid_q;
  logic [NUM_STAGES:0]   en;

  assign en[NUM_STAGES] = !stall_i;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end

  assign valid_d = {valid_q[NUM_STAGES-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  assign stall_o = !en[ST_ADDR];
  assign valid_o = valid_q[ST_OUT];

  // --------------------------------------------------------------------------
  // Address stage
  // --------------------------------------------------------------------------
  logic [PHASE_WIDTH-1:0]    phase_adj;
  logic [PHASE_WIDTH+TB-1:0] phase_ext;
  logic [TB-1:0]             idx;
  logic [1:0]                nb_ofs [4];
  logic [TB-1:0]             nb_idx [4];
  logic [TB-3:0]             row_q  [4];
  logic [1:0]                sel_q  [2];
  logic [FRACTION_BITS-1:0]  frac_q [7];

  assign phase_adj = kind_i ? phase_i + QUARTER_TURN : phase_i;
  assign phase_ext = {{TB{1'b0}}, phase_adj} >> FRACTION_BITS;
  assign idx       = phase_ext[TB-1:0];

  // bank b holds the neighbor whose index is b modulo 4
  for (genvar b = 0; b < 4; b++) begin : g_addr
    assign nb_ofs[b] = 2'(b) - idx[1:0] + 2'd1;
    assign nb_idx[b] = idx + TB'(nb_ofs[b]) - TB'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_ADDR]) begin
      for (int b = 0; b < 4; b++) begin
        row_q[b] <= nb_idx[b][TB-1:2];
      end
      sel_q[0]  <= idx[1:0];
      frac_q[0] <= phase_adj[FRACTION_BITS-1:0];
    end
    if (en[ST_ROM]) begin
      sel_q[1] <= sel_q[0];
    end
    for (int k = 1; k < 7; k++) begin
      if (en[k]) begin
        frac_q[k] <= frac_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Table read
  // --------------------------------------------------------------------------
  logic signed [ROM_WIDTH-1:0] bank_data [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    sct_rom_bank #(
      .TABLE_BITS (TB),
      .BANK       (b)
    ) u_bank (
      .clk_i  (clk_i),
      .en_i   (en[ST_ROM]),
      .row_i  (row_q[b]),
      .data_o (bank_data[b])
    );
  end

  // --------------------------------------------------------------------------
  // Coefficient stage
  // --------------------------------------------------------------------------
  logic signed [ROM_WIDTH-1:0]  y0, y1, y2, y3;
  logic signed [COEF_WIDTH-1:0] y0e, y1e, y2e, y3e;
  logic signed [COEF_WIDTH-1:0] a0, a1, a2, a3;
  logic signed [T_WIDTH-1:0]    t0_q;
  logic signed [COEF_WIDTH-1:0] a1_q [2];
  logic signed [COEF_WIDTH-1:0] a2_q [4];
  logic signed [COEF_WIDTH-1:0] a3_q [6];

  always_comb begin
    case (sel_q[1])
      2'd0: begin
        y0 = bank_data[3]; y1 = bank_data[0]; y2 = bank_data[1]; y3 = bank_data[2];
      end
      2'd1: begin
        y0 = bank_data[0]; y1 = bank_data[1]; y2 = bank_data[2]; y3 = bank_data[3];
      end
      2'd2: begin
        y0 = bank_data[1]; y1 = bank_data[2]; y2 = bank_data[3]; y3 = bank_data[0];
      end
      default: begin
        y0 = bank_data[2]; y1 = bank_data[3]; y2 = bank_data[0]; y3 = bank_data[1];
      end
    endcase
  end

  assign y0e = COEF_WIDTH'(y0);
  assign y1e = COEF_WIDTH'(y1);
  assign y2e = COEF_WIDTH'(y2);
  assign y3e = COEF_WIDTH'(y3);

  assign a0 = (y3e - y0e) + ((y1e - y2e) <<< 1) + (y1e - y2e);
  assign a1 = (y0e <<< 1) - (y1e <<< 2) - y1e + (y2e <<< 2) - y3e;
  assign a2 = y2e - y0e;
  assign a3 = y1e <<< 1;

  always_ff @(posedge clk_i) begin
    if (en[ST_COEF]) begin
      t0_q    <= T_WIDTH'(a0) <<< GUARD_BITS;
      a1_q[0] <= a1;
      a2_q[0] <= a2;
      a3_q[0] <= a3;
    end
    if (en[ST_MUL1]) begin
      a1_q[1] <= a1_q[0];
    end
    for (int k = 1; k < 4; k++) begin
      if (en[ST_COEF + k]) begin
        a2_q[k] <= a2_q[k-1];
      end
    end
    for (int k = 1; k < 6; k++) begin
      if (en[ST_COEF + k]) begin
        a3_q[k] <= a3_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Horner steps
  // --------------------------------------------------------------------------
  step_en_t                  step_en [3];
  logic signed [T_WIDTH-1:0] t1, t2, t3;

  assign step_en[0] = '{mul: en[ST_MUL1], acc: en[ST_ACC1]};
  assign step_en[1] = '{mul: en[ST_MUL2], acc: en[ST_ACC2]};
  assign step_en[2] = '{mul: en[ST_MUL3], acc: en[ST_ACC3]};

  sct_horner_step #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_step1 (
    .clk_i  (clk_i),
    .en_i   (step_en[0]),
    .t_i    (t0_q),
    .frac_i (frac_q[ST_COEF]),
    .coef_i (a1_q[1]),
    .t_o    (t1)
  );

  sct_horner_step #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_step2 (
    .clk_i  (clk_i),
    .en_i   (step_en[1]),
    .t_i    (t1),
    .frac_i (frac_q[ST_ACC1]),
    .coef_i (a2_q[3]),
    .t_o    (t2)
  );

  sct_horner_step #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_step3 (
    .clk_i  (clk_i),
    .en_i   (step_en[2]),
    .t_i    (t2),
    .frac_i (frac_q[ST_ACC2]),
    .coef_i (a3_q[5]),
    .t_o    (t3)
  );

  // --------------------------------------------------------------------------
  // Round half up and saturate
  // --------------------------------------------------------------------------
  logic signed [T_WIDTH:0]       rnd;
  logic signed [T_WIDTH:0]       shifted;
  logic signed [OUTPUT_BITS-1:0] value_d, value_q;

  assign rnd     = (T_WIDTH + 1)'(t3) + ROUND_HALF;
  assign shifted = rnd >>> ROUND_SHIFT;

  always_comb begin
    if (shifted > SAT_HI) begin
      value_d = SAT_HI[OUTPUT_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      value_d = SAT_LO[OUTPUT_BITS-1:0];
    end else begin
      value_d = shifted[OUTPUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

@@ rtl/core/sct_rom_bank.sv @@
// ============================================================================
// sct_rom_bank
// One quarter of the sine table: entries whose index is BANK modulo 4,
// read through a registered port.
// ============================================================================
module sct_rom_bank import sct_pkg::*; #(
  parameter int unsigned TABLE_BITS = $clog2(DEF_TABLE_SIZE),
  parameter int unsigned BANK       = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [TABLE_BITS-3:0]       row_i,
  output logic signed [ROM_WIDTH-1:0] data_o
);

  localparam int unsigned ROWS = 2 ** (TABLE_BITS - 2);

  logic [ROM_WIDTH-1:0] rom [ROWS];
  logic [ROM_WIDTH-1:0] data_q;

  for (genvar r = 0; r < ROWS; r++) begin : g_rom
    localparam logic [ROM_WIDTH-1:0] ENTRY = rom_entry((r << 2) + BANK, TABLE_BITS);
    assign rom[r] = ENTRY;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom[row_i];
    end
  end

  assign data_o = $signed(data_q);

endmodule

@@ rtl/core/sct_horner_step.sv @@
// ============================================================================
// sct_horner_step
// One Horner step t' = floor(t*f / 2^FRACTION_BITS) + coef*2^16 over two
// stages: split partial products, then sum, scale and add.
// ============================================================================
module sct_horner_step import sct_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                         clk_i,
  input  step_en_t                     en_i,
  input  logic signed [T_WIDTH-1:0]    t_i,
  input  logic [FRACTION_BITS-1:0]     frac_i,
  input  logic signed [COEF_WIDTH-1:0] coef_i,
  output logic signed [T_WIDTH-1:0]    t_o
);

  localparam int unsigned HI_W  = T_WIDTH - MUL_SPLIT;
  localparam int unsigned PH_W  = HI_W + FRACTION_BITS + 1;
  localparam int unsigned PL_W  = MUL_SPLIT + FRACTION_BITS;
  localparam int unsigned PW    = T_WIDTH + FRACTION_BITS + 1;

  logic signed [PH_W-1:0]    p_hi_d, p_hi_q;
  logic [PL_W-1:0]           p_lo_d, p_lo_q;
  logic signed [PW-1:0]      prod;
  logic signed [PW-1:0]      scaled;
  logic signed [T_WIDTH-1:0] t_d, t_q;

  assign p_hi_d = $signed(t_i[T_WIDTH-1:MUL_SPLIT]) * $signed({1'b0, frac_i});
  assign p_lo_d = t_i[MUL_SPLIT-1:0] * frac_i;

  assign prod   = (PW'(p_hi_q) <<< MUL_SPLIT) + $signed({{(PW-PL_W){1'b0}}, p_lo_q});
  assign scaled = prod >>> FRACTION_BITS;
  assign t_d    = $signed(scaled[T_WIDTH-1:0]) + (T_WIDTH'(coef_i) <<< GUARD_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      p_hi_q <= p_hi_d;
      p_lo_q <= p_lo_d;
    end
    if (en_i.acc) begin
      t_q <= t_d;
    end
  end

  assign t_o = t_q;

endmodule

@@ rtl/core/sct_checker.sv @@
// ============================================================================
// sct_checker
// Port-level checks of the sine/cosine interpolator, bound to the top level.
// ============================================================================
module sct_checker import sct_pkg::*; #(
  parameter int unsigned OUTPUT_BITS = DEF_OUTPUT_BITS
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          valid_i,
  input logic                          stall_o,
  input logic                          valid_o,
  input logic                          stall_i,
  input logic signed [OUTPUT_BITS-1:0] value_o
);

  // length of a quiet run after which the pipe must be empty
  localparam int unsigned DRAIN_EDGES = 11;

  // no result shows once reset has been seen
  a_reset_idle : assert property (@(posedge clk_i)
    !rst_ni |=> !valid_o)
    else $error("valid_o high during reset");

  // input side backs up only when the pipe is full and the result is held
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("stall_o without a held result");

  // a held result keeps its value until its transfer
  a_hold_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(value_o)))
    else $error("held result dropped or changed");

  // with no input transfer and a free output long enough, the pipe runs empty
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(valid_i && !stall_o) && !stall_i) [*DRAIN_EDGES] |-> !valid_o)
    else $error("result without a matching input transfer");

endmodule

bind sine_cosine_table_cubic_interp sct_checker #(
  .OUTPUT_BITS (OUTPUT_BITS)
) u_sct_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (valid_i),
  .stall_o (stall_o),
  .valid_o (valid_o),
  .stall_i (stall_i),
  .value_o (value_o)
);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: sine/cosine table with cubic interpolation
// Sends angle transfers (sine or cosine of a 24-bit phase) through the
// valid/stall handshake and checks every result against an in-bench
// Catmull-Rom predictor with its own copy of the Q1.15 sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sct_pkg::PHASE_WIDTH;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned ROUND_SHIFT = 17;
  localparam int unsigned LATENCY     = 10;
  localparam logic [PHASE_WIDTH-1:0] QTR_TURN = 24'h40_0000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam int unsigned N_DIRECTED = 10;
  localparam logic [PHASE_WIDTH-1:0] DIRECTED_PHASE [N_DIRECTED] = '{
    24'h00_0000, 24'hFF_FFFF, 24'h40_0000, 24'hC0_0000, 24'h00_0FFF,
    24'hFF_F000, 24'hFF_E800, 24'h80_0000, 24'h3F_FFFF, 24'h00_1001};
  localparam logic [11:0] EDGE_INDEX [10] = '{
    12'd0, 12'd1, 12'd1023, 12'd1024, 12'd2047, 12'd2048, 12'd3071, 12'd3072,
    12'd4094, 12'd4095};
  localparam logic [11:0] EDGE_FRAC [4] = '{12'd0, 12'd1, 12'd2048, 12'd4095};

  typedef struct packed {
    logic                   kind;
    logic [PHASE_WIDTH-1:0] phase;
  } angle_t;

  typedef struct packed {
    logic                   kind;
    logic [PHASE_WIDTH-1:0] phase;
    logic signed [15:0]     value;
  } trig_result_t;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   valid_i = 1'b0;
  logic                   kind_i  = 1'b0;
  logic [PHASE_WIDTH-1:0] phase_i = '0;
  logic                   stall_i = 1'b0;
  logic                   stall_o;
  logic                   valid_o;
  logic signed [15:0]     value_o;

  logic signed [15:0] sin_lut [TABLE_DEPTH];
  angle_t             angle_queue [$];
  trig_result_t       expected_results [$];
  angle_t             next_angle;
  trig_result_t       oldest;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        error_count   = 0;
  int unsigned        sine_count    = 0;
  int unsigned        cosine_count  = 0;
  int unsigned        checked_count = 0;

  sine_cosine_table_cubic_interp dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .kind_i  (kind_i),
    .phase_i (phase_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .value_o (value_o)
  );

  always #2 clk_i = ~clk_i;

  // Q30 Taylor series of sin or cos on [0, pi/2)
  function automatic longint unsigned taylor_q30(longint unsigned arg, bit use_cos);
    longint unsigned arg2;
    longint unsigned term;
    longint unsigned n;
    longint          sum;
    int              k;
    arg2 = (arg * arg) >> 30;
    term = use_cos ? ONE_Q30 : arg;
    n    = use_cos ? 64'd1 : 64'd2;
    sum  = longint'(term);
    for (k = 1; k < 10; k++) begin
      term = ((term * arg2) >> 30) / (n * (n + 64'd1));
      n    = n + 64'd2;
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return longint'(sum);
  endfunction

  function automatic logic signed [15:0] lut_entry(int unsigned i);
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned arg;
    longint unsigned mag;
    quad = (64'(i) * 64'd4) / TABLE_DEPTH;
    rem  = 64'(i) * 64'd4 - quad * TABLE_DEPTH;
    arg  = (HALF_PI_Q30 * rem + TABLE_DEPTH / 2) / TABLE_DEPTH;
    mag  = (taylor_q30(arg, quad[0]) + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? -16'(mag) : 16'(mag);
  endfunction

  function automatic logic signed [15:0] predict_trig(logic kind,
                                                      logic [PHASE_WIDTH-1:0] phase);
    logic [PHASE_WIDTH-1:0] ang;
    logic [11:0]            idx;
    longint                 y0, y1, y2, y3, f, t, v;
    ang = kind ? phase + QTR_TURN : phase;
    idx = ang[23:12];
    f   = ang[FRAC_BITS-1:0];
    y0  = sin_lut[idx - 12'd1];
    y1  = sin_lut[idx];
    y2  = sin_lut[idx + 12'd1];
    y3  = sin_lut[idx + 12'd2];
    t = (-y0 + 3 * y1 - 3 * y2 + y3) * 65536;
    t = ((t * f) >>> FRAC_BITS) + (2 * y0 - 5 * y1 + 4 * y2 - y3) * 65536;
    t = ((t * f) >>> FRAC_BITS) + (y2 - y0) * 65536;
    t = ((t * f) >>> FRAC_BITS) + 2 * y1 * 65536;
    v = (t + 65536) >>> ROUND_SHIFT;
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return 16'(v);
  endfunction

  task automatic log_failure(string msg);
    if (error_count < 10) begin
      $display("%t ERROR: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic queue_random_angles(int unsigned count);
    angle_t a;
    for (int unsigned n = 0; n < count; n++) begin
      a.kind = 1'($urandom());
      case ($urandom_range(9))
        5, 6: a.phase = {EDGE_INDEX[$urandom_range(9)], 12'($urandom())};
        7, 8: a.phase = {12'($urandom()), EDGE_FRAC[$urandom_range(3)]};
        9: a.phase = ($urandom_range(1) ? 24'h40_0000 : 24'hC0_0000) - 24'd4096
                     + 24'($urandom_range(8191));
        default: a.phase = 24'($urandom());
      endcase
      angle_queue.push_back(a);
    end
  endtask

  // All queued angles transferred and every result back
  task automatic wait_drained();
    do @(negedge clk_i); while (angle_queue.size() != 0 || valid_i);
    do @(negedge clk_i); while (expected_results.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      kind_i  <= 1'b0;
      phase_i <= '0;
    end else begin
      if (valid_i && !stall_o) begin
        expected_results.push_back('{kind_i, phase_i, predict_trig(kind_i, phase_i)});
        if (kind_i) begin
          cosine_count++;
        end else begin
          sine_count++;
        end
      end
      if (!valid_i || !stall_o) begin
        if (angle_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_angle = angle_queue.pop_front();
          valid_i <= 1'b1;
          kind_i  <= next_angle.kind;
          phase_i <= next_angle.phase;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      if (valid_o && !stall_i) begin
        if (expected_results.size() == 0) begin
          log_failure($sformatf("unexpected result %0d", value_o));
        end else begin
          oldest = expected_results.pop_front();
          checked_count++;
          if (value_o !== oldest.value) begin
            log_failure($sformatf("kind %0d phase %h: expected %0d, got %0d",
                                  oldest.kind, oldest.phase, oldest.value, value_o));
          end
        end
      end
      stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      sin_lut[i] = lut_entry(i);
    end
    send_idle_pct = 24;
    recv_idle_pct = 46;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < 2; k++) begin
      for (int unsigned p = 0; p < N_DIRECTED; p++) begin
        angle_queue.push_back('{1'(k), DIRECTED_PHASE[p]});
      end
    end
    queue_random_angles(230);
    wait_drained();

    send_idle_pct = 46;
    recv_idle_pct = 24;
    queue_random_angles(250);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_angles(250);
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Covered %0d sine and %0d cosine transfers, %0d results checked.",
             sine_count, cosine_count, checked_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sct_pkg.sv
rtl/core/sct_rom_bank.sv
rtl/core/sct_horner_step.sv
rtl/core/sine_cosine_table_cubic_interp.sv
rtl/core/sct_checker.sv
sim/tb_top.sv
